### rtl/core/api_frame_deframer_assert.svh
// Assertion macros used by the frame deframer parser RTL.
// Expects clk and arst_n in scope at every use.
`ifndef API_FRAME_DEFRAMER_ASSERT_SVH
`define API_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define AFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define AFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/afd_pkg.sv
// Package for the API frame deframer: payload structs, event codes, constants.
// No dependencies; imported by every module in rtl/core.
package afd_pkg;

	localparam int MAX_LENGTH = 256;

	localparam logic [7:0]  HDR_API       = 8'h7E;
	localparam logic [7:0]  TXT_O         = 8'h4F;
	localparam logic [7:0]  TXT_K         = 8'h4B;
	localparam logic [7:0]  TXT_CR        = 8'h0D;
	localparam logic [7:0]  SUM_OK        = 8'hFF;
	localparam logic [15:0] TIMEOUT_RESET = 16'd500;

	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_BYTE     = 3'd1;
	localparam logic [2:0] EV_GOOD     = 3'd2;
	localparam logic [2:0] EV_BADSUM   = 3'd3;
	localparam logic [2:0] EV_TXTOK    = 3'd4;
	localparam logic [2:0] EV_TXTABORT = 3'd5;
	localparam logic [2:0] EV_TIMEOUT  = 3'd6;
	localparam logic [2:0] EV_BADLEN   = 3'd7;

	localparam logic [0:0] OP_BYTE = 1'b0;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  payload_byte;
		logic [7:0]  byte_index;
		logic [15:0] frame_length;
		logic [7:0]  frame_type;
	} out_item_t;

	// Control from the top-level stage to the parser.
	typedef struct packed {
		logic        step;
		logic [15:0] timeout_ticks;
	} ctrl_t;

endpackage

### rtl/core/afd_parser.sv
// Frame/text parser state and its per-item next-state and result logic.
// Depends on afd_pkg and api_frame_deframer_assert.svh.
`include "api_frame_deframer_assert.svh"

module afd_parser
	import afd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_t     ctrl,
	input  in_item_t  item,
	output out_item_t result
);

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_LEN_HI  = 3'd1,
		PH_LEN_LO  = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CHECK   = 3'd4,
		PH_TXT_K   = 3'd5,
		PH_TXT_CR  = 3'd6
	} phase_t;

	localparam logic [15:0] MAX_LEN_W = 16'(MAX_LENGTH);

	phase_t      phase_q,   phase_d;
	logic [15:0] length_q,  length_d;
	logic [8:0]  left_q,    left_d;
	logic [7:0]  pos_q,     pos_d;
	logic [7:0]  sum_q,     sum_d;
	logic [7:0]  type_q,    type_d;
	logic [15:0] elapsed_q, elapsed_d;

	logic [16:0] tick_cnt;
	logic [15:0] len_full;
	logic [7:0]  sum_next;

	assign tick_cnt = {1'b0, elapsed_q} + 17'd1;
	assign len_full = {length_q[15:8], item.rx_byte};
	assign sum_next = sum_q + item.rx_byte;

	always_comb begin
		phase_d   = phase_q;
		length_d  = length_q;
		left_d    = left_q;
		pos_d     = pos_q;
		sum_d     = sum_q;
		type_d    = type_q;
		elapsed_d = elapsed_q;
		result    = '0;
		if (item.op != OP_BYTE[0]) begin
			// tick: only counts while something is in progress
			if (phase_q != PH_IDLE) begin
				if (tick_cnt > {1'b0, ctrl.timeout_ticks}) begin
					result.event_res    = EV_TIMEOUT;
					result.frame_length = length_q;
					phase_d   = PH_IDLE;
					left_d    = '0;
					pos_d     = '0;
					sum_d     = '0;
					elapsed_d = '0;
				end else begin
					elapsed_d = tick_cnt[15:0];
				end
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (item.rx_byte == HDR_API || item.rx_byte == TXT_O) begin
						phase_d   = (item.rx_byte == HDR_API) ? PH_LEN_HI : PH_TXT_K;
						length_d  = '0;
						left_d    = '0;
						pos_d     = '0;
						sum_d     = '0;
						elapsed_d = '0;
					end
				end
				PH_LEN_HI: begin
					length_d = {item.rx_byte, 8'h00};
					phase_d  = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					length_d = len_full;
					if (len_full == '0 || len_full > MAX_LEN_W) begin
						result.event_res    = EV_BADLEN;
						result.frame_length = len_full;
						phase_d   = PH_IDLE;
						left_d    = '0;
						pos_d     = '0;
						sum_d     = '0;
						elapsed_d = '0;
					end else begin
						left_d  = len_full[8:0];
						phase_d = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					result.event_res    = EV_BYTE;
					result.payload_byte = item.rx_byte;
					result.byte_index   = pos_q;
					result.frame_length = length_q;
					if (pos_q == '0)
						type_d = item.rx_byte;
					sum_d  = sum_next;
					left_d = left_q - 9'd1;
					if (left_q == 9'd1)
						phase_d = PH_CHECK;
					else
						pos_d = pos_q + 8'd1;
				end
				PH_CHECK: begin
					result.frame_length = length_q;
					if (sum_next == SUM_OK) begin
						result.event_res  = EV_GOOD;
						result.frame_type = type_q;
					end else begin
						result.event_res = EV_BADSUM;
					end
					phase_d   = PH_IDLE;
					left_d    = '0;
					pos_d     = '0;
					sum_d     = '0;
					elapsed_d = '0;
				end
				PH_TXT_K: begin
					if (item.rx_byte == TXT_K) begin
						phase_d = PH_TXT_CR;
					end else begin
						result.event_res = EV_TXTABORT;
						phase_d   = PH_IDLE;
						left_d    = '0;
						pos_d     = '0;
						sum_d     = '0;
						elapsed_d = '0;
					end
				end
				PH_TXT_CR: begin
					result.event_res = (item.rx_byte == TXT_CR) ? EV_TXTOK : EV_TXTABORT;
					phase_d   = PH_IDLE;
					left_d    = '0;
					pos_d     = '0;
					sum_d     = '0;
					elapsed_d = '0;
				end
				default: begin
					phase_d   = PH_IDLE;
					left_d    = '0;
					pos_d     = '0;
					sum_d     = '0;
					elapsed_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			length_q  <= '0;
			left_q    <= '0;
			pos_q     <= '0;
			sum_q     <= '0;
			type_q    <= '0;
			elapsed_q <= '0;
		end else if (ctrl.step) begin
			phase_q   <= phase_d;
			length_q  <= length_d;
			left_q    <= left_d;
			pos_q     <= pos_d;
			sum_q     <= sum_d;
			type_q    <= type_d;
			elapsed_q <= elapsed_d;
		end
	end

	// idle always means a clean slate for the counters
	`AFD_ASSERT_NOW(a_idle_clean, phase_q == PH_IDLE, elapsed_q == '0 && left_q == '0 && pos_q == '0, "idle with stale counters")
	// a byte in the payload phase always streams out
	`AFD_ASSERT_NOW(a_payload_ev, ctrl.step && phase_q == PH_PAYLOAD && item.op == OP_BYTE[0], result.event_res == EV_BYTE, "payload byte not reported")
	// last payload byte leads to the checksum phase
	`AFD_ASSERT_NEXT(a_last_byte, ctrl.step && phase_q == PH_PAYLOAD && item.op == OP_BYTE[0] && left_q == 9'd1, phase_q == PH_CHECK, "missed checksum phase")
	// remaining count never runs dry while still in payload
	`AFD_ASSERT_NOW(a_left_nz, phase_q == PH_PAYLOAD, left_q != '0, "payload phase with zero bytes left")

endmodule

### rtl/core/afd_result_reg.sv
// Output register for result transactions; while a result waits unaccepted, it holds the parser.
// Depends on afd_pkg.
module afd_result_reg
	import afd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  out_item_t load_item,
	output logic      can_load,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic      valid_q;
	out_item_t item_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			item_q <= load_item;
	end

endmodule

### rtl/core/api_frame_deframer.sv
// API frame deframer top level: input stage, timeout register, parser, result register.
// Depends on afd_pkg, afd_parser, afd_result_reg.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  in      | input     | in_valid / in_ready   | in_item  (op, rx_byte)
//  out     | output    | out_valid / out_ready | out_item (event, byte, index,
//          |           |                       |           length, type)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_data (timeout_ticks)
//
// Every input transaction yields exactly one output transaction; it is
// registered in the input register, then its result in the result
// register. Sustained rate is one transaction per cycle while out_ready
// stays high; the parser state update is combinational logic between those two registers.
// Reset clears all control state and loads timeout_ticks with 500.
// A stall on out backs up through the result register into in_ready.
module api_frame_deframer
	import afd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	// input stage
	logic      valid_s1;
	in_item_t  item_s1;
	logic      res_can_load;
	logic      advance;
	logic [15:0] timeout_q;
	ctrl_t     ctrl;
	out_item_t result;

	// the item in s1 moves on when the result register can take its result
	assign advance  = valid_s1 && res_can_load;
	assign in_ready = !valid_s1 || res_can_load;

	// register is always writable; writes must land only while idle, a user contract the block does not enforce
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			timeout_q <= TIMEOUT_RESET;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (cfg_valid)
				timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_item;
	end

	assign ctrl.step          = advance;
	assign ctrl.timeout_ticks = timeout_q;

	afd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.item   (item_s1),
		.result (result)
	);

	afd_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.load_item (result),
		.can_load  (res_can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
